FILE: hw/rtl/hmtvn_pkg.sv
package hmtvn_pkg;

   // field and datapath widths
   localparam int HGT_W   = 8;
   localparam int DIM_W   = 9;
   localparam int VEC_W   = 19;
   localparam int LEN_W   = 38;
   localparam int RES_W   = 16;
   localparam int DNUM_W  = 24;
   localparam int DDEN_W  = 10;

   // request kinds
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_READ  = 1'b1;

   // register indexes
   localparam logic CSR_GRID_WIDTH = 1'b0;
   localparam logic CSR_GRID_DEPTH = 1'b1;

   // sequencing limits
   localparam logic [3:0] NB_CENTER     = 4'd4;
   localparam logic [3:0] NB_LAST       = 4'd8;
   localparam logic [2:0] FACE_COUNT    = 3'd6;
   localparam logic [1:0] COMP_LAST     = 2'd2;
   localparam logic [3:0] BIT_TOP       = 4'd15;
   localparam logic [4:0] DIV_LAST_STEP = 5'd23;

   // divider jobs
   localparam logic [1:0] DIV_VERT_Y = 2'd0;
   localparam logic [1:0] DIV_TEX_U  = 2'd1;
   localparam logic [1:0] DIV_TEX_V  = 2'd2;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_WRITE,
      ST_RD_ADDR,
      ST_RD_CAP,
      ST_FACE_SEL,
      ST_VEC_LOAD,
      ST_LEN_SQ,
      ST_LEN_ACC,
      ST_MAG,
      ST_TSQ,
      ST_PLO,
      ST_PHI,
      ST_CMP,
      ST_COMP_END,
      ST_DIV_LOAD,
      ST_DIV_STEP,
      ST_DIV_STORE,
      ST_RESP
   } ctl_state_type;

   typedef struct packed {
      logic       latch;
      logic       mem_wr;
      logic       mem_rd;
      logic       nb_cap;
      logic [3:0] nb_idx;
      logic       vec_load;
      logic [2:0] face_idx;
      logic       use_acc;
      logic       len_sq;
      logic       len_acc;
      logic [1:0] comp;
      logic       mag_load;
      logic       tsq;
      logic       plo;
      logic       phi;
      logic       cmp;
      logic [3:0] bit_idx;
      logic       comp_done;
      logic       div_load;
      logic [1:0] div_sel;
      logic       div_step;
      logic       div_store;
      logic       resp;
   } dp_cmd_type;

   typedef struct packed {
      logic       range_err;
      logic       is_write;
      logic [5:0] face_en;
   } dp_status_type;

endpackage

FILE: hw/rtl/hmtvn_datapath.sv
module hmtvn_datapath #(
   parameter int MAX_COLS = 256,
   parameter int MAX_ROWS = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_type,
   input  logic [7:0]                   req_row,
   input  logic [7:0]                   req_col,
   input  logic [7:0]                   req_height_in,
   input  logic [hmtvn_pkg::DIM_W-1:0]  grid_w,
   input  logic [hmtvn_pkg::DIM_W-1:0]  grid_d,
   input  hmtvn_pkg::dp_cmd_type        cmd,
   output hmtvn_pkg::dp_status_type     status,
   output logic                         rsp_valid,
   output logic [7:0]                   rsp_vert_x,
   output logic [7:0]                   rsp_vert_z,
   output logic [12:0]                  rsp_vert_y,
   output logic [15:0]                  rsp_tex_u,
   output logic [15:0]                  rsp_tex_v,
   output logic signed [15:0]           rsp_normal_x,
   output logic signed [15:0]           rsp_normal_y,
   output logic signed [15:0]           rsp_normal_z,
   output logic                         rsp_range_error
);

   localparam int STORE  = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W = $clog2(STORE);

   // latched request
   logic       type_ff;
   logic [7:0] row_ff, col_ff, hin_ff;

   // height store
   logic [7:0] mem [STORE];
   logic [7:0] mem_q_ff;
   logic [ADDR_W-1:0] addr;

   // 3x3 neighborhood, row-major around the vertex
   logic [7:0] nb_ff [9];

   // normalizer
   logic signed [18:0] vec_ff [3];
   logic signed [18:0] acc_ff [3];
   logic signed [15:0] nrm_ff [3];
   logic [37:0] len2_ff, msq_ff;
   logic [31:0] tsq_ff;
   logic [50:0] plo_ff, phi_ff;
   logic [15:0] res_ff;

   // divider
   logic [23:0] dnum_ff;
   logic [9:0]  drem_ff, dden_ff;

   logic [12:0] vy_ff;
   logic [15:0] tu_ff, tv_ff;

   logic rsp_valid_ff;

   // ---------------- status ----------------
   logic up, down, left, right;
   always_comb begin
      up    = row_ff != 8'd0;
      left  = col_ff != 8'd0;
      down  = ({1'b0, row_ff} + 9'd1) < grid_d;
      right = ({1'b0, col_ff} + 9'd1) < grid_w;
      status.range_err = ({1'b0, row_ff} >= grid_d) || ({1'b0, col_ff} >= grid_w);
      status.is_write  = type_ff == hmtvn_pkg::REQ_WRITE;
      status.face_en   = {down & right, down & left, down & left,
                          up & left, up & right, up & right};
   end

   // ---------------- neighbor address ----------------
   logic [1:0] dr, dc;
   logic [7:0] nrow, ncol;
   logic       nvalid;
   always_comb begin
      case (cmd.nb_idx)
         4'd0:    begin dr = 2'd0; dc = 2'd0; end
         4'd1:    begin dr = 2'd0; dc = 2'd1; end
         4'd2:    begin dr = 2'd0; dc = 2'd2; end
         4'd3:    begin dr = 2'd1; dc = 2'd0; end
         4'd4:    begin dr = 2'd1; dc = 2'd1; end
         4'd5:    begin dr = 2'd1; dc = 2'd2; end
         4'd6:    begin dr = 2'd2; dc = 2'd0; end
         4'd7:    begin dr = 2'd2; dc = 2'd1; end
         default: begin dr = 2'd2; dc = 2'd2; end
      endcase
      nrow   = row_ff + {6'd0, dr} - 8'd1;
      ncol   = col_ff + {6'd0, dc} - 8'd1;
      nvalid = !(dr == 2'd0 && !up) && !(dr == 2'd2 && !down) &&
               !(dc == 2'd0 && !left) && !(dc == 2'd2 && !right) &&
               !status.range_err;
      addr   = nvalid ? ADDR_W'(int'(nrow) * MAX_COLS + int'(ncol)) : '0;
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_wr) mem[addr] <= hin_ff;
      if (cmd.mem_rd) mem_q_ff <= mem[addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         type_ff <= req_type;
         row_ff  <= req_row;
         col_ff  <= req_col;
         hin_ff  <= req_height_in;
      end
      if (cmd.nb_cap) nb_ff[cmd.nb_idx] <= mem_q_ff;
   end

   // ---------------- face direction ----------------
   function automatic logic signed [8:0] hdiff(input logic [7:0] a, input logic [7:0] b);
      hdiff = $signed({1'b0, a}) - $signed({1'b0, b});
   endfunction

   logic signed [8:0] fx, fz;
   always_comb begin
      case (cmd.face_idx)
         3'd0:    begin fx = hdiff(nb_ff[4], nb_ff[5]); fz = hdiff(nb_ff[2], nb_ff[5]); end
         3'd1:    begin fx = hdiff(nb_ff[1], nb_ff[2]); fz = hdiff(nb_ff[1], nb_ff[4]); end
         3'd2:    begin fx = hdiff(nb_ff[3], nb_ff[4]); fz = hdiff(nb_ff[1], nb_ff[4]); end
         3'd3:    begin fx = hdiff(nb_ff[6], nb_ff[7]); fz = hdiff(nb_ff[4], nb_ff[7]); end
         3'd4:    begin fx = hdiff(nb_ff[3], nb_ff[4]); fz = hdiff(nb_ff[3], nb_ff[6]); end
         default: begin fx = hdiff(nb_ff[4], nb_ff[5]); fz = hdiff(nb_ff[4], nb_ff[7]); end
      endcase
   end

   // ---------------- normalizer ----------------
   logic [18:0]        mag;
   logic [37:0]        mag_sq;
   logic [15:0]        trial;
   logic [15:0]        t16;
   logic [31:0]        t_sq;
   logic [50:0]        p_lo, p_hi;
   logic [69:0]        prod, rhs;
   logic               neg;
   logic signed [16:0] u;

   always_comb begin
      neg    = vec_ff[cmd.comp][18];
      mag    = neg ? 19'(-vec_ff[cmd.comp]) : 19'(vec_ff[cmd.comp]);
      mag_sq = {19'd0, mag} * {19'd0, mag};
      trial  = res_ff | (16'd1 << cmd.bit_idx);
      t16    = 16'({trial, 1'b0} - 17'd1);
      t_sq   = {16'd0, t16} * {16'd0, t16};
      p_lo   = {19'd0, tsq_ff} * {32'd0, len2_ff[18:0]};
      p_hi   = {19'd0, tsq_ff} * {32'd0, len2_ff[37:19]};
      prod   = {phi_ff, 19'd0} + {19'd0, plo_ff};
      rhs    = {msq_ff, 32'd0};
      u      = neg ? -$signed({1'b0, res_ff}) : $signed({1'b0, res_ff});
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         for (int i = 0; i < 3; i++) acc_ff[i] <= '0;
      end
      if (cmd.vec_load) begin
         len2_ff <= '0;
         if (cmd.use_acc) begin
            for (int i = 0; i < 3; i++) vec_ff[i] <= acc_ff[i];
         end else begin
            vec_ff[0] <= {{10{fx[8]}}, fx};
            vec_ff[1] <= 19'sd15;
            vec_ff[2] <= {{10{fz[8]}}, fz};
         end
      end
      if (cmd.len_sq) msq_ff <= mag_sq;
      if (cmd.len_acc) len2_ff <= len2_ff + msq_ff;
      if (cmd.mag_load) begin
         msq_ff <= mag_sq;
         res_ff <= '0;
      end
      if (cmd.tsq) tsq_ff <= t_sq;
      if (cmd.plo) plo_ff <= p_lo;
      if (cmd.phi) phi_ff <= p_hi;
      // keep the largest candidate whose rounding boundary does not exceed |c|/|v|
      if (cmd.cmp && prod <= rhs && len2_ff != '0 && !res_ff[15]) res_ff <= trial;
      if (cmd.comp_done) begin
         if (cmd.use_acc)
            nrm_ff[cmd.comp] <= (res_ff == 16'h8000 && !neg) ? 16'sh7FFF : u[15:0];
         else
            acc_ff[cmd.comp] <= acc_ff[cmd.comp] + {{2{u[16]}}, u};
      end
   end

   // ---------------- restoring divider ----------------
   logic [10:0] dtrial;
   logic        dge;
   always_comb begin
      dtrial = {drem_ff, dnum_ff[23]};
      dge    = dtrial >= {1'b0, dden_ff};
   end

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         drem_ff <= '0;
         case (cmd.div_sel)
            hmtvn_pkg::DIV_VERT_Y: begin
               dnum_ff <= {7'd0, nb_ff[4], 9'd0} + 24'd15;
               dden_ff <= 10'd30;
            end
            hmtvn_pkg::DIV_TEX_U: begin
               dnum_ff <= {col_ff, 16'd0} + {15'd0, grid_w - 9'd1};
               dden_ff <= {grid_w - 9'd1, 1'b0};
            end
            default: begin
               dnum_ff <= {row_ff, 16'd0} + {15'd0, grid_d - 9'd1};
               dden_ff <= {grid_d - 9'd1, 1'b0};
            end
         endcase
      end
      if (cmd.div_step) begin
         drem_ff <= dge ? 10'(dtrial - {1'b0, dden_ff}) : dtrial[9:0];
         dnum_ff <= {dnum_ff[22:0], dge};
      end
      if (cmd.div_store) begin
         case (cmd.div_sel)
            hmtvn_pkg::DIV_VERT_Y: vy_ff <= dnum_ff[12:0];
            hmtvn_pkg::DIV_TEX_U:  tu_ff <= dnum_ff[15:0];
            default:               tv_ff <= dnum_ff[15:0];
         endcase
      end
   end

   // ---------------- response ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.resp;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.resp) begin
         if (status.range_err) begin
            rsp_vert_x   <= '0;
            rsp_vert_z   <= '0;
            rsp_vert_y   <= '0;
            rsp_tex_u    <= '0;
            rsp_tex_v    <= '0;
            rsp_normal_x <= '0;
            rsp_normal_y <= '0;
            rsp_normal_z <= '0;
         end else begin
            rsp_vert_x   <= col_ff;
            rsp_vert_z   <= row_ff;
            rsp_vert_y   <= vy_ff;
            rsp_tex_u    <= tu_ff;
            rsp_tex_v    <= tv_ff;
            rsp_normal_x <= nrm_ff[0];
            rsp_normal_y <= nrm_ff[1];
            rsp_normal_z <= nrm_ff[2];
         end
         rsp_range_error <= status.range_err;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: hw/rtl/hmtvn_ctrl.sv
module hmtvn_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  hmtvn_pkg::dp_status_type status,
   output logic                     busy,
   output hmtvn_pkg::dp_cmd_type    cmd
);

   hmtvn_pkg::ctl_state_type state_ff, state_in;
   logic [3:0] fidx_ff, fidx_in;
   logic [2:0] face_ff, face_in;
   logic       final_ff, final_in;
   logic [1:0] comp_ff, comp_in;
   logic [3:0] bit_ff, bit_in;
   logic [1:0] dsel_ff, dsel_in;
   logic [4:0] dcnt_ff, dcnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hmtvn_pkg::ST_IDLE;
         fidx_ff  <= '0;
         face_ff  <= '0;
         final_ff <= 1'b0;
         comp_ff  <= '0;
         bit_ff   <= '0;
         dsel_ff  <= '0;
         dcnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fidx_ff  <= fidx_in;
         face_ff  <= face_in;
         final_ff <= final_in;
         comp_ff  <= comp_in;
         bit_ff   <= bit_in;
         dsel_ff  <= dsel_in;
         dcnt_ff  <= dcnt_in;
      end
   end

   // next state and sequencing counters
   always_comb begin
      state_in = state_ff;
      fidx_in  = fidx_ff;
      face_in  = face_ff;
      final_in = final_ff;
      comp_in  = comp_ff;
      bit_in   = bit_ff;
      dsel_in  = dsel_ff;
      dcnt_in  = dcnt_ff;
      unique case (state_ff)
         hmtvn_pkg::ST_IDLE: begin
            if (start) state_in = hmtvn_pkg::ST_DECIDE;
         end
         hmtvn_pkg::ST_DECIDE: begin
            if (status.range_err) begin
               state_in = hmtvn_pkg::ST_RESP;
            end else if (status.is_write) begin
               state_in = hmtvn_pkg::ST_WRITE;
            end else begin
               fidx_in  = '0;
               state_in = hmtvn_pkg::ST_RD_ADDR;
            end
         end
         hmtvn_pkg::ST_WRITE:   state_in = hmtvn_pkg::ST_IDLE;
         hmtvn_pkg::ST_RD_ADDR: state_in = hmtvn_pkg::ST_RD_CAP;
         hmtvn_pkg::ST_RD_CAP: begin
            if (fidx_ff == hmtvn_pkg::NB_LAST) begin
               face_in  = '0;
               final_in = 1'b0;
               state_in = hmtvn_pkg::ST_FACE_SEL;
            end else begin
               fidx_in  = fidx_ff + 4'd1;
               state_in = hmtvn_pkg::ST_RD_ADDR;
            end
         end
         hmtvn_pkg::ST_FACE_SEL: begin
            if (face_ff == hmtvn_pkg::FACE_COUNT) begin
               final_in = 1'b1;
               state_in = hmtvn_pkg::ST_VEC_LOAD;
            end else if (status.face_en[face_ff]) begin
               state_in = hmtvn_pkg::ST_VEC_LOAD;
            end else begin
               face_in = face_ff + 3'd1;
            end
         end
         hmtvn_pkg::ST_VEC_LOAD: begin
            comp_in  = '0;
            state_in = hmtvn_pkg::ST_LEN_SQ;
         end
         hmtvn_pkg::ST_LEN_SQ: state_in = hmtvn_pkg::ST_LEN_ACC;
         hmtvn_pkg::ST_LEN_ACC: begin
            if (comp_ff == hmtvn_pkg::COMP_LAST) begin
               comp_in  = '0;
               state_in = hmtvn_pkg::ST_MAG;
            end else begin
               comp_in  = comp_ff + 2'd1;
               state_in = hmtvn_pkg::ST_LEN_SQ;
            end
         end
         hmtvn_pkg::ST_MAG: begin
            bit_in   = hmtvn_pkg::BIT_TOP;
            state_in = hmtvn_pkg::ST_TSQ;
         end
         hmtvn_pkg::ST_TSQ: state_in = hmtvn_pkg::ST_PLO;
         hmtvn_pkg::ST_PLO: state_in = hmtvn_pkg::ST_PHI;
         hmtvn_pkg::ST_PHI: state_in = hmtvn_pkg::ST_CMP;
         hmtvn_pkg::ST_CMP: begin
            if (bit_ff == 4'd0) begin
               state_in = hmtvn_pkg::ST_COMP_END;
            end else begin
               bit_in   = bit_ff - 4'd1;
               state_in = hmtvn_pkg::ST_TSQ;
            end
         end
         hmtvn_pkg::ST_COMP_END: begin
            if (comp_ff == hmtvn_pkg::COMP_LAST) begin
               if (final_ff) begin
                  dsel_in  = hmtvn_pkg::DIV_VERT_Y;
                  state_in = hmtvn_pkg::ST_DIV_LOAD;
               end else begin
                  face_in  = face_ff + 3'd1;
                  state_in = hmtvn_pkg::ST_FACE_SEL;
               end
            end else begin
               comp_in  = comp_ff + 2'd1;
               state_in = hmtvn_pkg::ST_MAG;
            end
         end
         hmtvn_pkg::ST_DIV_LOAD: begin
            dcnt_in  = '0;
            state_in = hmtvn_pkg::ST_DIV_STEP;
         end
         hmtvn_pkg::ST_DIV_STEP: begin
            if (dcnt_ff == hmtvn_pkg::DIV_LAST_STEP) state_in = hmtvn_pkg::ST_DIV_STORE;
            else dcnt_in = dcnt_ff + 5'd1;
         end
         hmtvn_pkg::ST_DIV_STORE: begin
            if (dsel_ff == hmtvn_pkg::DIV_TEX_V) begin
               state_in = hmtvn_pkg::ST_RESP;
            end else begin
               dsel_in  = dsel_ff + 2'd1;
               state_in = hmtvn_pkg::ST_DIV_LOAD;
            end
         end
         hmtvn_pkg::ST_RESP: state_in = hmtvn_pkg::ST_IDLE;
         default:            state_in = hmtvn_pkg::ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd          = '0;
      cmd.nb_idx   = fidx_ff;
      cmd.face_idx = face_ff;
      cmd.use_acc  = final_ff;
      cmd.comp     = comp_ff;
      cmd.bit_idx  = bit_ff;
      cmd.div_sel  = dsel_ff;
      unique case (state_ff)
         hmtvn_pkg::ST_IDLE:      cmd.latch = start;
         hmtvn_pkg::ST_WRITE: begin
            cmd.mem_wr = 1'b1;
            cmd.nb_idx = hmtvn_pkg::NB_CENTER;
         end
         hmtvn_pkg::ST_RD_ADDR:   cmd.mem_rd    = 1'b1;
         hmtvn_pkg::ST_RD_CAP:    cmd.nb_cap    = 1'b1;
         hmtvn_pkg::ST_VEC_LOAD:  cmd.vec_load  = 1'b1;
         hmtvn_pkg::ST_LEN_SQ:    cmd.len_sq    = 1'b1;
         hmtvn_pkg::ST_LEN_ACC:   cmd.len_acc   = 1'b1;
         hmtvn_pkg::ST_MAG:       cmd.mag_load  = 1'b1;
         hmtvn_pkg::ST_TSQ:       cmd.tsq       = 1'b1;
         hmtvn_pkg::ST_PLO:       cmd.plo       = 1'b1;
         hmtvn_pkg::ST_PHI:       cmd.phi       = 1'b1;
         hmtvn_pkg::ST_CMP:       cmd.cmp       = 1'b1;
         hmtvn_pkg::ST_COMP_END:  cmd.comp_done = 1'b1;
         hmtvn_pkg::ST_DIV_LOAD:  cmd.div_load  = 1'b1;
         hmtvn_pkg::ST_DIV_STEP:  cmd.div_step  = 1'b1;
         hmtvn_pkg::ST_DIV_STORE: cmd.div_store = 1'b1;
         hmtvn_pkg::ST_RESP:      cmd.resp      = 1'b1;
         default:                 cmd.latch     = 1'b0;
      endcase
   end

   assign busy = state_ff != hmtvn_pkg::ST_IDLE;

endmodule

FILE: hw/rtl/heightmap_terrain_vertex_normals.sv
// Height-grid vertex unit with smooth per-vertex normals.
//
// Request channel: a request is taken on a rising edge with start high and
// busy low. req_type selects a height write or a vertex read at
// (req_row, req_col). A write stores req_height_in and returns nothing; a read
// returns position, vert_y, texcoords and a Q1.15 unit normal. A position
// outside the configured grid returns one response with rsp_range_error set
// and all other fields zero, for writes as well as reads.
// Response channel: rsp_valid marks each response for exactly one cycle; the
// receiver has no way to stall it and must take it then.
// Config: csr_index 0 = grid width, 1 = grid depth, written when csr_valid and
// csr_ready are high; csr_ready follows !busy.
// Work: a read runs nine neighbor fetches through the single store port, up to
// seven normalizations (16 search steps per component, each through TSQ, PLO,
// PHI and CMP on one shared multiplier chain), and three 24-step divisions.
// Reset returns the controller to idle and the grid size to 256 x 256; the
// height store is not cleared, so read only around written vertices.
module heightmap_terrain_vertex_normals #(
   parameter int MAX_COLS = 256,
   parameter int MAX_ROWS = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_type,
   input  logic [7:0]          req_row,
   input  logic [7:0]          req_col,
   input  logic [7:0]          req_height_in,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic                csr_index,
   input  logic [8:0]          csr_wdata,
   output logic                rsp_valid,
   output logic [7:0]          rsp_vert_x,
   output logic [7:0]          rsp_vert_z,
   output logic [12:0]         rsp_vert_y,
   output logic [15:0]         rsp_tex_u,
   output logic [15:0]         rsp_tex_v,
   output logic signed [15:0]  rsp_normal_x,
   output logic signed [15:0]  rsp_normal_y,
   output logic signed [15:0]  rsp_normal_z,
   output logic                rsp_range_error
);

   logic [8:0] grid_width_ff, grid_depth_ff;
   logic [8:0] eff_w, eff_d;

   hmtvn_pkg::dp_cmd_type    cmd;
   hmtvn_pkg::dp_status_type status;

   assign csr_ready = ~busy;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff <= 9'd256;
         grid_depth_ff <= 9'd256;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == hmtvn_pkg::CSR_GRID_WIDTH) grid_width_ff <= csr_wdata;
         else grid_depth_ff <= csr_wdata;
      end
   end

   // clamp sizes into 2..MAX
   always_comb begin
      eff_w = grid_width_ff;
      if (grid_width_ff < 9'd2) eff_w = 9'd2;
      else if (32'(grid_width_ff) > MAX_COLS) eff_w = 9'(MAX_COLS);
      eff_d = grid_depth_ff;
      if (grid_depth_ff < 9'd2) eff_d = 9'd2;
      else if (32'(grid_depth_ff) > MAX_ROWS) eff_d = 9'(MAX_ROWS);
   end

   hmtvn_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   hmtvn_datapath #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_type        (req_type),
      .req_row         (req_row),
      .req_col         (req_col),
      .req_height_in   (req_height_in),
      .grid_w          (eff_w),
      .grid_d          (eff_d),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_vert_x      (rsp_vert_x),
      .rsp_vert_z      (rsp_vert_z),
      .rsp_vert_y      (rsp_vert_y),
      .rsp_tex_u       (rsp_tex_u),
      .rsp_tex_v       (rsp_tex_v),
      .rsp_normal_x    (rsp_normal_x),
      .rsp_normal_y    (rsp_normal_y),
      .rsp_normal_z    (rsp_normal_z),
      .rsp_range_error (rsp_range_error)
   );

   // a response is only issued at the tail of a request
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("response without a request in flight");

   // the controller is back in idle while the response shows
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while still busy");

   // an accepted request always occupies the unit
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but unit not busy");

   // out-of-range responses carry a zero normal y component
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_range_error) |-> (rsp_normal_y == 16'sd0))
      else $error("range error response with nonzero data");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import hmtvn_pkg::*;

   // one vertex response as it appears on the rsp_ ports
   typedef struct packed {
      logic        range_error;
      logic [7:0]  vert_x;
      logic [7:0]  vert_z;
      logic [12:0] vert_y;
      logic [15:0] tex_u;
      logic [15:0] tex_v;
      logic [15:0] normal_x;
      logic [15:0] normal_y;
      logic [15:0] normal_z;
   } vertex_t;

   // Mirror of the height grid plus the queue of vertices still owed by the block.
   class vertex_board;
      byte unsigned heights[65536];
      bit           written[65536];
      int unsigned  width_reg = 256;
      int unsigned  depth_reg = 256;
      vertex_t      owed[$];
      int           errors = 0;

      function int unsigned eff(int unsigned v);
         if (v < 2) return 2;
         if (v > 256) return 256;
         return v;
      endfunction

      function int unsigned grid_w();
         return eff(width_reg);
      endfunction

      function int unsigned grid_d();
         return eff(depth_reg);
      endfunction

      function void set_reg(logic idx, int unsigned val);
         if (idx == CSR_GRID_WIDTH) width_reg = val & 9'h1ff;
         else depth_reg = val & 9'h1ff;
      endfunction

      function longint hgt(int unsigned r, int unsigned c);
         int unsigned idx;
         idx = r * 256 + c;
         return (idx < 65536) ? longint'(heights[idx]) : 0;
      endfunction

      // round(c * 32768 / sqrt(len2)), ties away from zero, by exact search
      function longint unit_comp(longint c, longint unsigned len2);
         bit [127:0]       target;
         bit [127:0]       prod;
         longint unsigned  mag;
         longint unsigned  t;
         int unsigned      lo;
         int unsigned      hi;
         int unsigned      mid;
         if (len2 == 0) return 0;
         mag = (c < 0) ? -c : c;
         target = (128'(mag) * 128'(mag)) << 32;
         lo = 0;
         hi = 32768;
         while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            t = 2 * mid - 1;
            prod = 128'(t * t) * 128'(len2);
            if (prod <= target) lo = mid;
            else hi = mid - 1;
         end
         return (c < 0) ? -longint'(lo) : longint'(lo);
      endfunction

      function void normalize(input longint vx, vy, vz, output longint ux, uy, uz);
         longint unsigned len2;
         len2 = vx * vx + vy * vy + vz * vz;
         ux = unit_comp(vx, len2);
         uy = unit_comp(vy, len2);
         uz = unit_comp(vz, len2);
      endfunction

      function void add_face(inout longint ax, ay, az, input longint x, z);
         longint ux, uy, uz;
         normalize(x, 15, z, ux, uy, uz);
         ax += ux;
         ay += uy;
         az += uz;
      endfunction

      // triangle (i+1,j) (i+1,j+1) (i,j+1)
      function void tri_a(inout longint ax, ay, az, input int unsigned i, j);
         add_face(ax, ay, az, hgt(i + 1, j) - hgt(i + 1, j + 1),
                  hgt(i, j + 1) - hgt(i + 1, j + 1));
      endfunction

      // triangle (i+1,j) (i,j+1) (i,j)
      function void tri_b(inout longint ax, ay, az, input int unsigned i, j);
         add_face(ax, ay, az, hgt(i, j) - hgt(i, j + 1), hgt(i, j) - hgt(i + 1, j));
      endfunction

      function logic [15:0] sat16(longint v);
         if (v > 32767) v = 32767;
         if (v < -32768) v = -32768;
         return v[15:0];
      endfunction

      function void note_request(logic kind, logic [7:0] r, logic [7:0] c, logic [7:0] h);
         vertex_t         e;
         int unsigned     w;
         int unsigned     d;
         longint          ax;
         longint          ay;
         longint          az;
         longint          nx;
         longint          ny;
         longint          nz;
         longint unsigned hv;
         w = grid_w();
         d = grid_d();
         e = '0;
         if (r >= d || c >= w) begin
            // out of grid: flagged response, writes too
            e.range_error = 1'b1;
            owed.push_back(e);
            return;
         end
         if (kind == REQ_WRITE) begin
            heights[r * 256 + c] = h;
            written[r * 256 + c] = 1'b1;
            return;
         end
         ax = 0;
         ay = 0;
         az = 0;
         // up to six faces around the vertex, clipped at the grid edge
         if (r >= 1 && c + 1 < w) begin
            tri_a(ax, ay, az, r - 1, c);
            tri_b(ax, ay, az, r - 1, c);
         end
         if (r >= 1 && c >= 1) tri_a(ax, ay, az, r - 1, c - 1);
         if (r + 1 < d && c >= 1) begin
            tri_a(ax, ay, az, r, c - 1);
            tri_b(ax, ay, az, r, c - 1);
         end
         if (r + 1 < d && c + 1 < w) tri_b(ax, ay, az, r, c);
         normalize(ax, ay, az, nx, ny, nz);
         hv = hgt(r, c);
         e.vert_x = c;
         e.vert_z = r;
         e.vert_y = (hv * 512 + 15) / 30;
         e.tex_u = (longint'(c) * 65536 + (w - 1)) / (2 * (w - 1));
         e.tex_v = (longint'(r) * 65536 + (d - 1)) / (2 * (d - 1));
         e.normal_x = sat16(nx);
         e.normal_y = sat16(ny);
         e.normal_z = sat16(nz);
         owed.push_back(e);
      endfunction

      function void cmp_field(string name, longint e, longint a);
         if (e != a) begin
            $display("%0t mismatch %s: expected %0d actual %0d", $time, name, e, a);
            errors++;
         end
      endfunction

      function void check_response(vertex_t got);
         vertex_t e;
         if (owed.size() == 0) begin
            $display("%0t unexpected response: expected none actual %p", $time, got);
            errors++;
            return;
         end
         e = owed.pop_front();
         cmp_field("range_error", e.range_error, got.range_error);
         cmp_field("vert_x", e.vert_x, got.vert_x);
         cmp_field("vert_z", e.vert_z, got.vert_z);
         cmp_field("vert_y", e.vert_y, got.vert_y);
         cmp_field("tex_u", e.tex_u, got.tex_u);
         cmp_field("tex_v", e.tex_v, got.tex_v);
         cmp_field("normal_x", $signed(e.normal_x), $signed(got.normal_x));
         cmp_field("normal_y", $signed(e.normal_y), $signed(got.normal_y));
         cmp_field("normal_z", $signed(e.normal_z), $signed(got.normal_z));
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic               req_type;
   logic [7:0]         req_row;
   logic [7:0]         req_col;
   logic [7:0]         req_height_in;
   logic               csr_valid;
   logic               csr_ready;
   logic               csr_index;
   logic [8:0]         csr_wdata;
   logic               rsp_valid;
   logic [7:0]         rsp_vert_x;
   logic [7:0]         rsp_vert_z;
   logic [12:0]        rsp_vert_y;
   logic [15:0]        rsp_tex_u;
   logic [15:0]        rsp_tex_v;
   logic signed [15:0] rsp_normal_x;
   logic signed [15:0] rsp_normal_y;
   logic signed [15:0] rsp_normal_z;
   logic               rsp_range_error;

   vertex_board board = new();
   int          requests_sent = 0;

   heightmap_terrain_vertex_normals dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_row(req_row), .req_col(req_col),
      .req_height_in(req_height_in),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid), .rsp_vert_x(rsp_vert_x), .rsp_vert_z(rsp_vert_z),
      .rsp_vert_y(rsp_vert_y), .rsp_tex_u(rsp_tex_u), .rsp_tex_v(rsp_tex_v),
      .rsp_normal_x(rsp_normal_x), .rsp_normal_y(rsp_normal_y),
      .rsp_normal_z(rsp_normal_z), .rsp_range_error(rsp_range_error)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // responses cannot be stalled: take each one on the edge that ends it
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         board.check_response({rsp_range_error, rsp_vert_x, rsp_vert_z, rsp_vert_y,
                               rsp_tex_u, rsp_tex_v, rsp_normal_x, rsp_normal_y,
                               rsp_normal_z});
      end
   end

   // Issue one request; start stays high on return so back-to-back requests
   // never see a low/high pair in one step. Random gaps, except for a long
   // burst stretch in the middle of the run.
   task automatic send_request(logic kind, int unsigned r, int unsigned c, int unsigned h);
      if (!(requests_sent >= 500 && requests_sent < 700) && $urandom_range(99) < 38) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      start <= 1'b1;
      req_type <= kind;
      req_row <= r[7:0];
      req_col <= c[7:0];
      req_height_in <= h[7:0];
      do @(posedge clock); while (busy);
      board.note_request(kind, r[7:0], c[7:0], h[7:0]);
      requests_sent++;
   endtask

   // drain: no request in flight and nothing owed, then let a write finish
   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (busy || board.owed.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(logic idx, int unsigned val);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[8:0];
      do @(posedge clock); while (!csr_ready);
      board.set_reg(idx, val);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // a read is only legal once every in-grid 3x3 neighbor has a height
   function automatic bit can_read(int r, int c);
      int w;
      int d;
      w = board.grid_w();
      d = board.grid_d();
      for (int dr = -1; dr <= 1; dr++)
         for (int dc = -1; dc <= 1; dc++)
            if (r + dr >= 0 && r + dr < d && c + dc >= 0 && c + dc < w)
               if (!board.written[(r + dr) * 256 + c + dc]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic int unsigned pick_height();
      case ($urandom_range(7))
         0: return 0;
         1: return 255;
         default: return $urandom_range(255);
      endcase
   endfunction

   // One grid setting: fill a patch (whole grid when small), then a random mix
   // of reads, rewrites and out-of-grid requests.
   task automatic run_phase(int unsigned wv, int unsigned dv, bit flat);
      int unsigned w;
      int unsigned d;
      int unsigned pw;
      int unsigned pd;
      int unsigned r0;
      int unsigned c0;
      int unsigned level;
      int unsigned r;
      int unsigned c;
      int unsigned tries;
      int unsigned op;
      csr_write(CSR_GRID_WIDTH, wv);
      csr_write(CSR_GRID_DEPTH, dv);
      w = board.grid_w();
      d = board.grid_d();
      pw = (w <= 12) ? w : 6;
      pd = (d <= 12) ? d : 6;
      c0 = $urandom_range(1) ? w - pw : $urandom_range(w - pw);
      r0 = $urandom_range(1) ? d - pd : $urandom_range(d - pd);
      level = $urandom_range(255);
      for (int unsigned i = 0; i < pd; i++)
         for (int unsigned j = 0; j < pw; j++)
            send_request(REQ_WRITE, r0 + i, c0 + j, flat ? level : pick_height());
      repeat (60) begin
         op = $urandom_range(99);
         r = r0 + $urandom_range(pd - 1);
         c = c0 + $urandom_range(pw - 1);
         if (op < 45) begin
            tries = 0;
            while (!can_read(r, c) && tries < 20) begin
               r = r0 + $urandom_range(pd - 1);
               c = c0 + $urandom_range(pw - 1);
               tries++;
            end
            if (can_read(r, c)) send_request(REQ_READ, r, c, $urandom_range(255));
            else send_request(REQ_WRITE, r, c, pick_height());
         end else if (op < 75 || (w == 256 && d == 256)) begin
            send_request(REQ_WRITE, r, c, flat ? level : pick_height());
         end else begin
            // outside the grid on one axis or the other
            if (w < 256 && (d == 256 || $urandom_range(1))) begin
               c = $urandom_range(w, 255);
               r = $urandom_range(255);
            end else begin
               r = $urandom_range(d, 255);
               c = $urandom_range(255);
            end
            send_request($urandom_range(1), r, c, $urandom_range(255));
         end
      end
   endtask

   initial begin
      int unsigned wv;
      int unsigned dv;
      reset = 1'b1;
      start = 1'b0;
      req_type = REQ_WRITE;
      req_row = '0;
      req_col = '0;
      req_height_in = '0;
      csr_valid = 1'b0;
      csr_index = CSR_GRID_WIDTH;
      csr_wdata = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: both far corners at reset size, steep and extreme heights
      send_request(REQ_WRITE, 0, 0, 0);
      send_request(REQ_WRITE, 0, 1, 255);
      send_request(REQ_WRITE, 1, 0, 255);
      send_request(REQ_WRITE, 1, 1, 0);
      send_request(REQ_READ, 0, 0, 0);
      send_request(REQ_WRITE, 255, 255, 255);
      send_request(REQ_WRITE, 255, 254, 0);
      send_request(REQ_WRITE, 254, 255, 128);
      send_request(REQ_WRITE, 254, 254, 17);
      send_request(REQ_READ, 255, 255, 255);
      // hold off until the grid is quiet
      wait_drained();
      // register values below the minimum act as a 2 x 2 grid
      csr_write(CSR_GRID_WIDTH, 0);
      csr_write(CSR_GRID_DEPTH, 1);
      send_request(REQ_READ, 1, 1, 0);
      send_request(REQ_READ, 0, 1, 0);
      send_request(REQ_WRITE, 2, 0, 99);
      send_request(REQ_READ, 0, 2, 0);
      send_request(REQ_READ, 255, 255, 0);
      // above the maximum clamps to full size
      csr_write(CSR_GRID_WIDTH, 511);
      csr_write(CSR_GRID_DEPTH, 300);
      send_request(REQ_READ, 255, 255, 0);
      send_request(REQ_READ, 1, 0, 0);

      run_phase(4, 4, 1'b1);
      run_phase(2, 2, 1'b0);
      run_phase(256, 256, 1'b0);
      run_phase(3, 2, 1'b0);
      run_phase(511, 0, 1'b0);
      while (requests_sent < 1350) begin
         case ($urandom_range(9))
            0: wv = $urandom_range(1);
            1: wv = $urandom_range(257, 511);
            2: wv = $urandom_range(11, 256);
            default: wv = $urandom_range(2, 10);
         endcase
         case ($urandom_range(9))
            0: dv = $urandom_range(1);
            1: dv = $urandom_range(257, 511);
            2: dv = $urandom_range(11, 256);
            default: dv = $urandom_range(2, 10);
         endcase
         run_phase(wv, dv, $urandom_range(4) == 0);
      end

      start <= 1'b0;
      do @(posedge clock); while (board.owed.size() != 0);
      // leave room for a stray response after a full read
      repeat (2000) @(posedge clock);
      if (board.errors == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

   initial begin
      #40_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
